FILE: rtl/hpr_pkg.sv
// Shared types and constants for the histogram percentile range core.
// Payload structs, configuration snapshot, register indices, saturating add.
// No dependencies.
`default_nettype none
package hpr_pkg;

  localparam int BIN_W    = 24;
  localparam int FRAC_W   = 17;
  localparam int EXIDX_W  = 8;
  localparam int BOUND_W  = 9;
  localparam int TOTAL_W  = 32;
  localparam int ADDR_W   = 5;
  localparam int REGIDX_W = 3;

  localparam logic [REGIDX_W-1:0] REG_LOWER_FRAC = 3'd0;
  localparam logic [REGIDX_W-1:0] REG_UPPER_FRAC = 3'd1;
  localparam logic [REGIDX_W-1:0] REG_LOWER_OPEN = 3'd2;
  localparam logic [REGIDX_W-1:0] REG_UPPER_OPEN = 3'd3;
  localparam logic [REGIDX_W-1:0] REG_EXCL_EN    = 3'd4;
  localparam logic [REGIDX_W-1:0] REG_EXCL_FIRST = 3'd5;
  localparam logic [REGIDX_W-1:0] REG_EXCL_LAST  = 3'd6;

  localparam logic [FRAC_W-1:0] UPPER_FRAC_RST = 17'h10000;

  typedef struct packed {
    logic [BIN_W-1:0] bin_count;
    logic             last_bin;
  } hpr_in_t;

  typedef struct packed {
    logic [BOUND_W-1:0] low_bin;
    logic [BOUND_W-1:0] high_bin;
    logic [TOTAL_W-1:0] total_count;
  } hpr_out_t;

  typedef struct packed {
    logic [FRAC_W-1:0]  lower_fraction;
    logic [FRAC_W-1:0]  upper_fraction;
    logic               lower_open;
    logic               upper_open;
    logic               exclude_enable;
    logic [EXIDX_W-1:0] exclude_first;
    logic [EXIDX_W-1:0] exclude_last;
  } hpr_cfg_t;

  function automatic logic [TOTAL_W-1:0] hpr_sat_add(input logic [TOTAL_W-1:0] a,
                                                     input logic [TOTAL_W-1:0] b);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/hpr_queue.sv
// Two-entry job queue between the bin loader and the scan engine.
// Generic width; no package dependency.
`default_nettype none
module hpr_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              not_empty,
  output logic              full
);

  logic [W-1:0] ent_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         do_push, do_pop;

  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign not_empty = cnt_r != 2'd0;
  assign full      = cnt_r == 2'd2;
  assign pop_data  = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/hpr_front.sv
// Bin loader: accepts items, writes bins to the store, queues a scan job on the last bin.
// Depends on hpr_pkg.
`default_nettype none
module hpr_front #(
  parameter int MAX_BINS   = 256,
  parameter int COUNT_BITS = 24
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic                                busy,
  input  wire hpr_pkg::hpr_in_t                    in_data,
  output logic                                     wr_en,
  output logic [$clog2(MAX_BINS)-1:0]              wr_addr,
  output logic [((COUNT_BITS < hpr_pkg::BIN_W) ?
                 COUNT_BITS : hpr_pkg::BIN_W)-1:0] wr_data,
  output logic                                     push,
  output logic [$clog2(MAX_BINS+1)-1:0]            job_n
);
  import hpr_pkg::*;

  localparam int IDX_W   = $clog2(MAX_BINS);
  localparam int CNT_W   = $clog2(MAX_BINS + 1);
  localparam int STORE_W = (COUNT_BITS < BIN_W) ? COUNT_BITS : BIN_W;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;
  logic             room;

  assign accept  = start && !busy;
  assign room    = cnt_r < CNT_W'(MAX_BINS);
  assign wr_en   = accept && room;
  assign wr_addr = cnt_r[IDX_W-1:0];
  assign wr_data = in_data.bin_count[STORE_W-1:0];
  assign push    = accept && in_data.last_bin;
  assign job_n   = room ? cnt_r + CNT_W'(1) : cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push) begin
      cnt_nxt = '0;
    end else if (wr_en) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/hpr_back.sv
// Scan engine: bin store, sum pass, threshold products, cumulative bound pass, result register.
// Depends on hpr_pkg.
`default_nettype none
module hpr_back #(
  parameter int MAX_BINS   = 256,
  parameter int COUNT_BITS = 24
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                wr_en,
  input  wire logic [$clog2(MAX_BINS)-1:0]         wr_addr,
  input  wire logic [((COUNT_BITS < hpr_pkg::BIN_W) ?
                      COUNT_BITS : hpr_pkg::BIN_W)-1:0] wr_data,
  input  wire logic                                job_valid,
  input  wire hpr_pkg::hpr_cfg_t                   job_cfg,
  input  wire logic [$clog2(MAX_BINS+1)-1:0]       job_n,
  output logic                                     job_pop,
  output logic                                     active,
  output logic                                     out_valid,
  output hpr_pkg::hpr_out_t                        out_data
);
  import hpr_pkg::*;

  localparam int IDX_W   = $clog2(MAX_BINS);
  localparam int CNT_W   = $clog2(MAX_BINS + 1);
  localparam int BND_W   = $clog2(MAX_BINS + 2);
  localparam int STORE_W = (COUNT_BITS < BIN_W) ? COUNT_BITS : BIN_W;
  localparam int PROD_W  = FRAC_W + TOTAL_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SUM  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_SCAN = 2'd3;

  logic [STORE_W-1:0] mem [MAX_BINS];

  logic [1:0]         state_r, state_nxt;
  hpr_cfg_t           cfg_r;
  logic [CNT_W-1:0]   n_r;
  logic [CNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               rd_en;
  logic [STORE_W-1:0] rd_data_r;
  logic               d_vld_r;
  logic [CNT_W-1:0]   d_idx_r;
  logic               d_last_r;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [TOTAL_W-1:0] cum_r, cum_nxt;
  logic [PROD_W-1:0]  lo_thr_r, hi_thr_r;
  logic               tz_r;
  logic [BND_W-1:0]   lb_r, lb_nxt, ub_r, ub_nxt;
  logic               lo_lat_r, lo_lat_nxt, hi_lat_r, hi_lat_nxt;
  logic               out_valid_r, out_valid_nxt;
  hpr_out_t           out_data_r;
  logic               excluded;
  logic [TOTAL_W-1:0] val;
  logic [PROD_W-1:0]  cum_sh;
  logic               reach_lo, reach_hi, upd_lo, upd_hi;
  logic [BND_W-1:0]   here;

  assign job_pop   = (state_r == S_IDLE) && job_valid;
  assign active    = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign rd_en     = ((state_r == S_SUM) || (state_r == S_SCAN)) && (rd_idx_r < n_r);

  assign excluded = cfg_r.exclude_enable &&
                    (32'(d_idx_r) >= 32'(cfg_r.exclude_first)) &&
                    (32'(d_idx_r) <= 32'(cfg_r.exclude_last));
  assign val      = excluded ? '0 : TOTAL_W'(rd_data_r);
  assign cum_nxt  = hpr_sat_add(cum_r, val);
  assign cum_sh   = {1'b0, cum_nxt, 16'h0000};
  assign reach_lo = tz_r ? (cfg_r.lower_fraction == '0) : (cum_sh >= lo_thr_r);
  assign reach_hi = tz_r ? (cfg_r.upper_fraction == '0) : (cum_sh >= hi_thr_r);
  assign upd_lo   = !lo_lat_r && (cfg_r.lower_open || reach_lo);
  assign upd_hi   = !hi_lat_r && (cfg_r.upper_open || reach_hi);
  assign here     = BND_W'(d_idx_r) + BND_W'(1);

  always_comb begin
    lb_nxt     = upd_lo ? here : lb_r;
    ub_nxt     = upd_hi ? here : ub_r;
    lo_lat_nxt = lo_lat_r || (upd_lo && !cfg_r.lower_open);
    hi_lat_nxt = hi_lat_r || (upd_hi && !cfg_r.upper_open);
    if (lb_nxt == ub_nxt) begin
      ub_nxt = ub_nxt + BND_W'(1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    rd_idx_nxt    = rd_en ? rd_idx_r + CNT_W'(1) : rd_idx_r;
    total_nxt     = total_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        rd_idx_nxt = '0;
        total_nxt  = '0;
        if (job_valid) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (d_vld_r) begin
          total_nxt = hpr_sat_add(total_r, val);
          if (d_last_r) begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        rd_idx_nxt = '0;
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        if (d_vld_r && d_last_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_idx_r    <= '0;
      d_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_idx_r    <= rd_idx_nxt;
      d_vld_r     <= rd_en;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx_r[IDX_W-1:0]];
      d_idx_r   <= rd_idx_r;
      d_last_r  <= rd_idx_r == n_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    total_r <= total_nxt;
    if (job_pop) begin
      cfg_r <= job_cfg;
      n_r   <= job_n;
    end
    if (state_r == S_MUL) begin
      lo_thr_r <= PROD_W'(cfg_r.lower_fraction) * PROD_W'(total_r);
      hi_thr_r <= PROD_W'(cfg_r.upper_fraction) * PROD_W'(total_r);
      tz_r     <= total_r == '0;
      cum_r    <= '0;
      lb_r     <= '0;
      ub_r     <= '0;
      lo_lat_r <= 1'b0;
      hi_lat_r <= 1'b0;
    end else if ((state_r == S_SCAN) && d_vld_r) begin
      cum_r    <= cum_nxt;
      lb_r     <= lb_nxt;
      ub_r     <= ub_nxt;
      lo_lat_r <= lo_lat_nxt;
      hi_lat_r <= hi_lat_nxt;
    end
    if (out_valid_nxt) begin
      out_data_r.low_bin     <= BOUND_W'(lb_nxt);
      out_data_r.high_bin    <= BOUND_W'(ub_nxt);
      out_data_r.total_count <= total_r;
    end
  end

`ifndef ASSERT_OFF
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_IDLE))
    else $error("bin store written during a scan");
  a_mul_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (!d_vld_r && !rd_en))
    else $error("read in flight at threshold step");
  a_done_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_SCAN) && (state_r == S_IDLE))
    else $error("result raised outside scan pass");
`endif

endmodule
`default_nettype wire

FILE: rtl/histogram_percentile_range_core.sv
// Histogram percentile range core: loads N bins, one per cycle while busy is low,
// then scans twice. The result strobe follows the sum pass, threshold step and scan
// pass; busy is high from the cycle after the last bin until the strobe, so no new
// histogram loads meanwhile. The bin store is read once per bin in each pass.
// Reset (rst_n low, synchronous) restores register defaults and idles; no store clearing.
// Results cannot be stalled: each is presented on out_valid for one cycle.
`default_nettype none
module histogram_percentile_range_core #(
  parameter int MAX_BINS   = 256,
  parameter int COUNT_BITS = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire hpr_pkg::hpr_in_t            in_data,
  output logic                             out_valid,
  output hpr_pkg::hpr_out_t                out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [hpr_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import hpr_pkg::*;

  localparam int IDX_W   = $clog2(MAX_BINS);
  localparam int CNT_W   = $clog2(MAX_BINS + 1);
  localparam int STORE_W = (COUNT_BITS < BIN_W) ? COUNT_BITS : BIN_W;
  localparam int JOB_W   = $bits(hpr_cfg_t) + CNT_W;

  hpr_cfg_t            cfg_r, cfg_nxt;
  logic [REGIDX_W-1:0] reg_idx;
  logic                cfg_we;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [STORE_W-1:0] wr_data;
  logic               push;
  logic [CNT_W-1:0]   front_n;
  logic [JOB_W-1:0]   q_out;
  logic               q_not_empty;
  logic               q_full;
  logic               job_pop;
  logic               back_active;
  hpr_cfg_t           job_cfg;
  logic [CNT_W-1:0]   job_n;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;
  assign busy    = q_not_empty || back_active;
  assign job_cfg = q_out[JOB_W-1:CNT_W];
  assign job_n   = q_out[CNT_W-1:0];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx)
        REG_LOWER_FRAC: cfg_nxt.lower_fraction = pwdata[FRAC_W-1:0];
        REG_UPPER_FRAC: cfg_nxt.upper_fraction = pwdata[FRAC_W-1:0];
        REG_LOWER_OPEN: cfg_nxt.lower_open     = pwdata[0];
        REG_UPPER_OPEN: cfg_nxt.upper_open     = pwdata[0];
        REG_EXCL_EN:    cfg_nxt.exclude_enable = pwdata[0];
        REG_EXCL_FIRST: cfg_nxt.exclude_first  = pwdata[EXIDX_W-1:0];
        REG_EXCL_LAST:  cfg_nxt.exclude_last   = pwdata[EXIDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LOWER_FRAC: prdata = 32'(cfg_r.lower_fraction);
      REG_UPPER_FRAC: prdata = 32'(cfg_r.upper_fraction);
      REG_LOWER_OPEN: prdata = 32'(cfg_r.lower_open);
      REG_UPPER_OPEN: prdata = 32'(cfg_r.upper_open);
      REG_EXCL_EN:    prdata = 32'(cfg_r.exclude_enable);
      REG_EXCL_FIRST: prdata = 32'(cfg_r.exclude_first);
      REG_EXCL_LAST:  prdata = 32'(cfg_r.exclude_last);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{lower_fraction: '0, upper_fraction: UPPER_FRAC_RST, lower_open: 1'b0,
                 upper_open: 1'b0, exclude_enable: 1'b0, exclude_first: '0,
                 exclude_last: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  hpr_front #(
    .MAX_BINS   (MAX_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .push    (push),
    .job_n   (front_n)
  );

  hpr_queue #(
    .W (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({cfg_r, front_n}),
    .pop       (job_pop),
    .pop_data  (q_out),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  hpr_back #(
    .MAX_BINS   (MAX_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .job_valid (q_not_empty),
    .job_cfg   (job_cfg),
    .job_n     (job_n),
    .job_pop   (job_pop),
    .active    (back_active),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("job queue overflow");
  a_last_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> busy)
    else $error("busy not raised after last bin");
  a_no_load_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !wr_en)
    else $error("bin written while busy");
`endif

endmodule
`default_nettype wire
